/* rtl/core/ptrr_pkg.sv */
`default_nettype none
package ptrr_pkg;

    localparam int NUM_SLOTS       = 16;
    localparam int SLOT_W          = 4;
    localparam int COUNT_W         = 5;
    localparam int QUANT_W         = 4;
    localparam int TIME_W          = 32;
    localparam int SCAN_CYCLES     = NUM_SLOTS + 1;
    localparam logic [QUANT_W-1:0] DEFAULT_QUANTUM = 4'd4;

    localparam logic CFG_PROCESS_COUNT = 1'b0;
    localparam logic CFG_TIME_QUANTUM  = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RR_DEMOTE,
        ST_RR_HEAD,
        ST_RR_PUSH,
        ST_PREEMPT,
        ST_PREEMPT_PUSH,
        ST_START,
        ST_DEMOTE_PREV,
        ST_PUSH_PREV,
        ST_RUN_BEST,
        ST_PUSH_BEST,
        ST_OUT
    } state_t;

    // Command broadcast along the row; the addressed cell acts on it
    typedef struct packed {
        logic              load;
        logic              wr_resp;
        logic              dec_rem;
        logic              set_dem;
        logic              slice_inc;
        logic              slice_clr;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       pid;
        logic [15:0]       arrival;
        logic [15:0]       burst;
        logic [7:0]        prio;
        logic [TIME_W-1:0] resp;
    } cell_cmd_t;

    // Contents of one cell as seen by the sequencer
    typedef struct packed {
        logic [15:0]        pid;
        logic [15:0]        arrival;
        logic [15:0]        burst;
        logic [15:0]        remaining;
        logic               demoted;
        logic               started;
        logic [TIME_W-1:0]  resp;
        logic [QUANT_W-1:0] slice;
    } cell_view_t;

    // Running winner handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        prio;
    } best_t;

endpackage
`default_nettype wire

/* rtl/core/priority_then_round_robin_scheduler_top.sv */
// Two-level process scheduler: a priority level over a round-robin level.
// Input channel (s_valid/s_ready): action 0 loads a table slot with pid,
// arrival, burst and priority; action 1 advances one time tick.
// Result channel (m_valid/m_ready): exactly one item per input item, giving
// the tick time, the slot that ran and its level, and any completion with
// its finish, response, turnaround and waiting times.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 = process count, 1 = time quantum); write only while idle.
// Sequence: a load's result is ready the cycle after it is accepted; a tick
// first passes the winner through the row of 16 slot cells, then takes a
// decision step, then the table or queue updates that it calls for, one per cycle.
// One item is in flight at a time; the next is accepted the cycle after
// the result is taken.
// Reset (aresetn low, synchronous): tick counter zero, queue empty, no
// previous runner, all slot flags clear, quantum 4, process count 0.
// A stalled receiver holds the result registers and blocks new items.
`default_nettype none
module priority_then_round_robin_scheduler_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [3:0]  s_slot,
    input  wire logic [15:0] s_pid,
    input  wire logic [15:0] s_arrival,
    input  wire logic [15:0] s_burst,
    input  wire logic [7:0]  s_priority_req,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_tick_time,
    output logic             m_ran_valid,
    output logic [3:0]       m_ran_slot,
    output logic             m_ran_level,
    output logic             m_done_valid,
    output logic [3:0]       m_done_slot,
    output logic [15:0]      m_done_pid,
    output logic [31:0]      m_finish_time,
    output logic [31:0]      m_response_time,
    output logic [31:0]      m_turnaround,
    output logic [31:0]      m_waiting,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data
);

    ptrr_pkg::cell_cmd_t                 cmd;
    ptrr_pkg::best_t                     chain [ptrr_pkg::NUM_SLOTS+1];
    ptrr_pkg::cell_view_t                views [ptrr_pkg::NUM_SLOTS];
    ptrr_pkg::cell_view_t                view_sel;
    logic [ptrr_pkg::SLOT_W-1:0]         rd_idx;
    logic [ptrr_pkg::COUNT_W-1:0]        slot_limit;
    logic [ptrr_pkg::TIME_W-1:0]         now;

    assign chain[0]  = '0;
    assign view_sel  = views[rd_idx];

    // Row of slot cells, winner handed along one cell per cycle
    for (genvar i = 0; i < ptrr_pkg::NUM_SLOTS; i++) begin : g_cell
        ptrr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (ptrr_pkg::SLOT_W'(i)),
            .slot_limit (slot_limit),
            .now        (now),
            .cmd        (cmd),
            .best_in    (chain[i]),
            .best_out   (chain[i+1]),
            .view       (views[i])
        );
    end

    ptrr_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_slot          (s_slot),
        .s_pid           (s_pid),
        .s_arrival       (s_arrival),
        .s_burst         (s_burst),
        .s_priority_req  (s_priority_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tick_time     (m_tick_time),
        .m_ran_valid     (m_ran_valid),
        .m_ran_slot      (m_ran_slot),
        .m_ran_level     (m_ran_level),
        .m_done_valid    (m_done_valid),
        .m_done_slot     (m_done_slot),
        .m_done_pid      (m_done_pid),
        .m_finish_time   (m_finish_time),
        .m_response_time (m_response_time),
        .m_turnaround    (m_turnaround),
        .m_waiting       (m_waiting),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .chain_best      (chain[ptrr_pkg::NUM_SLOTS]),
        .view            (view_sel),
        .cmd             (cmd),
        .rd_idx          (rd_idx),
        .slot_limit      (slot_limit),
        .now             (now)
    );

endmodule
`default_nettype wire

/* rtl/core/ptrr_cell.sv */
`default_nettype none
module ptrr_cell (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [ptrr_pkg::SLOT_W-1:0]      cell_idx,
    input  wire logic [ptrr_pkg::COUNT_W-1:0]     slot_limit,
    input  wire logic [ptrr_pkg::TIME_W-1:0]      now,
    input  wire ptrr_pkg::cell_cmd_t              cmd,
    input  wire ptrr_pkg::best_t                  best_in,
    output ptrr_pkg::best_t                       best_out,
    output ptrr_pkg::cell_view_t                  view
);

    logic [15:0]                  pid_reg;
    logic [15:0]                  arrival_reg;
    logic [15:0]                  burst_reg;
    logic [7:0]                   prio_reg;
    logic [15:0]                  remaining_reg;
    logic [ptrr_pkg::TIME_W-1:0]  resp_reg;
    logic                         demoted_reg;
    logic                         started_reg;
    logic [ptrr_pkg::QUANT_W-1:0] slice_reg;
    ptrr_pkg::best_t              best_reg;
    ptrr_pkg::best_t              best_next;
    logic                         hit;
    logic                         eligible;

    assign hit = (cmd.slot == cell_idx);

    // Eligible: in use, arrived, unfinished, still on level one
    assign eligible = ({1'b0, cell_idx} < slot_limit) &&
                      ({16'd0, arrival_reg} <= now) &&
                      (remaining_reg != 16'd0) && !demoted_reg;

    // Take over the running winner only on a strictly lower priority
    always_comb begin
        best_next = best_in;
        if (eligible && (!best_in.valid || prio_reg < best_in.prio)) begin
            best_next.valid = 1'b1;
            best_next.slot  = cell_idx;
            best_next.prio  = prio_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
        end else begin
            best_reg <= best_next;
        end
    end

    // Flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            demoted_reg <= 1'b0;
            started_reg <= 1'b0;
            slice_reg   <= '0;
        end else if (hit) begin
            if (cmd.load) begin
                demoted_reg <= 1'b0;
                started_reg <= 1'b0;
                slice_reg   <= '0;
            end else begin
                if (cmd.set_dem) begin
                    demoted_reg <= 1'b1;
                end
                if (cmd.wr_resp) begin
                    started_reg <= 1'b1;
                end
                if (cmd.slice_clr) begin
                    slice_reg <= '0;
                end else if (cmd.slice_inc) begin
                    slice_reg <= slice_reg + 1'b1;
                end
            end
        end
    end

    // Table payload
    always_ff @(posedge aclk) begin
        if (hit) begin
            if (cmd.load) begin
                pid_reg       <= cmd.pid;
                arrival_reg   <= cmd.arrival;
                burst_reg     <= cmd.burst;
                prio_reg      <= cmd.prio;
                remaining_reg <= cmd.burst;
            end else begin
                if (cmd.dec_rem) begin
                    remaining_reg <= remaining_reg - 16'd1;
                end
                if (cmd.wr_resp) begin
                    resp_reg <= cmd.resp;
                end
            end
        end
    end

    assign best_out       = best_reg;
    assign view.pid       = pid_reg;
    assign view.arrival   = arrival_reg;
    assign view.burst     = burst_reg;
    assign view.remaining = remaining_reg;
    assign view.demoted   = demoted_reg;
    assign view.started   = started_reg;
    assign view.resp      = resp_reg;
    assign view.slice     = slice_reg;

endmodule
`default_nettype wire

/* rtl/core/ptrr_ctrl.sv */
`default_nettype none
module ptrr_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_action,
    input  wire logic [3:0]                       s_slot,
    input  wire logic [15:0]                      s_pid,
    input  wire logic [15:0]                      s_arrival,
    input  wire logic [15:0]                      s_burst,
    input  wire logic [7:0]                       s_priority_req,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [31:0]                           m_tick_time,
    output logic                                  m_ran_valid,
    output logic [3:0]                            m_ran_slot,
    output logic                                  m_ran_level,
    output logic                                  m_done_valid,
    output logic [3:0]                            m_done_slot,
    output logic [15:0]                           m_done_pid,
    output logic [31:0]                           m_finish_time,
    output logic [31:0]                           m_response_time,
    output logic [31:0]                           m_turnaround,
    output logic [31:0]                           m_waiting,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [4:0]                       cfg_data,
    input  wire ptrr_pkg::best_t                  chain_best,
    input  wire ptrr_pkg::cell_view_t             view,
    output ptrr_pkg::cell_cmd_t                   cmd,
    output logic [ptrr_pkg::SLOT_W-1:0]           rd_idx,
    output logic [ptrr_pkg::COUNT_W-1:0]          slot_limit,
    output logic [ptrr_pkg::TIME_W-1:0]           now
);

    ptrr_pkg::state_t              state_reg, state_next;
    logic [ptrr_pkg::COUNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [31:0]                   tick_reg, tick_next;
    logic [ptrr_pkg::COUNT_W-1:0]  pcount_reg;
    logic [ptrr_pkg::QUANT_W-1:0]  quantum_reg;
    logic [ptrr_pkg::QUANT_W-1:0]  q;
    logic                          prev_valid_reg, prev_valid_next;
    logic [ptrr_pkg::SLOT_W-1:0]   prev_idx_reg, prev_idx_next;
    ptrr_pkg::best_t               best_reg, best_next;
    logic [ptrr_pkg::SLOT_W-1:0]   head_reg, head_next;
    logic [ptrr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [ptrr_pkg::SLOT_W-1:0]   fifo_mem [ptrr_pkg::NUM_SLOTS];
    logic                          fifo_we;
    logic [ptrr_pkg::SLOT_W-1:0]   fifo_waddr;
    logic [ptrr_pkg::SLOT_W-1:0]   fifo_head_reg;
    logic [ptrr_pkg::SLOT_W-1:0]   push_slot_reg, push_slot_next;
    logic [ptrr_pkg::SLOT_W-1:0]   rd_idx_reg, rd_idx_next;

    logic [31:0] r_tick_reg, r_tick_next;
    logic        r_ran_valid_reg, r_ran_valid_next;
    logic [3:0]  r_ran_slot_reg, r_ran_slot_next;
    logic        r_ran_level_reg, r_ran_level_next;
    logic        r_done_valid_reg, r_done_valid_next;
    logic [3:0]  r_done_slot_reg, r_done_slot_next;
    logic [15:0] r_done_pid_reg, r_done_pid_next;
    logic [31:0] r_finish_reg, r_finish_next;
    logic [31:0] r_resp_reg, r_resp_next;
    logic [31:0] r_tat_reg, r_tat_next;
    logic [31:0] r_wait_reg, r_wait_next;

    logic [31:0] d_finish;
    logic [31:0] d_tat;
    logic [31:0] d_wait;
    logic [15:0] new_rem;
    logic [4:0]  new_slice;
    logic [16:0] served;
    logic        best_differs;

    assign q          = (quantum_reg == '0) ? 4'd1 : quantum_reg;
    assign slot_limit = (pcount_reg > 5'(ptrr_pkg::NUM_SLOTS)) ?
                        5'(ptrr_pkg::NUM_SLOTS) : pcount_reg;
    assign now        = tick_reg;
    assign rd_idx     = rd_idx_reg;

    // Completion figures for the cell under view
    assign d_finish  = r_tick_reg + 32'd1;
    assign d_tat     = d_finish - {16'd0, view.arrival};
    assign d_wait    = d_tat - {16'd0, view.burst};
    assign new_rem   = view.remaining - 16'd1;
    assign new_slice = {1'b0, view.slice} + 5'd1;
    assign served    = {1'b0, view.burst} - {1'b0, new_rem};
    assign best_differs = (best_reg.valid != prev_valid_reg) ||
                          (best_reg.valid && best_reg.slot != prev_idx_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg  <= '0;
            quantum_reg <= ptrr_pkg::DEFAULT_QUANTUM;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ptrr_pkg::CFG_PROCESS_COUNT: pcount_reg  <= cfg_data;
                ptrr_pkg::CFG_TIME_QUANTUM:  quantum_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Round-robin queue storage; the head is read through a register, which
    // is settled by the decision cycle since the queue holds still while scanning
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= push_slot_reg;
        end
        fifo_head_reg <= fifo_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptrr_pkg::ST_IDLE;
            scan_cnt_reg   <= '0;
            tick_reg       <= '0;
            prev_valid_reg <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            tick_reg       <= tick_next;
            prev_valid_reg <= prev_valid_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_idx_reg      <= prev_idx_next;
        best_reg          <= best_next;
        push_slot_reg     <= push_slot_next;
        rd_idx_reg        <= rd_idx_next;
        r_tick_reg        <= r_tick_next;
        r_ran_valid_reg   <= r_ran_valid_next;
        r_ran_slot_reg    <= r_ran_slot_next;
        r_ran_level_reg   <= r_ran_level_next;
        r_done_valid_reg  <= r_done_valid_next;
        r_done_slot_reg   <= r_done_slot_next;
        r_done_pid_reg    <= r_done_pid_next;
        r_finish_reg      <= r_finish_next;
        r_resp_reg        <= r_resp_next;
        r_tat_reg         <= r_tat_next;
        r_wait_reg        <= r_wait_next;
    end

    // Sequencer: one table or queue update per cycle
    always_comb begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        tick_next         = tick_reg;
        prev_valid_next   = prev_valid_reg;
        prev_idx_next     = prev_idx_reg;
        best_next         = best_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        push_slot_next    = push_slot_reg;
        rd_idx_next       = rd_idx_reg;
        fifo_we           = 1'b0;
        fifo_waddr        = head_reg + count_reg[ptrr_pkg::SLOT_W-1:0];
        cmd               = '0;
        cmd.slot          = rd_idx_reg;
        s_ready           = 1'b0;
        m_valid           = 1'b0;
        r_tick_next       = r_tick_reg;
        r_ran_valid_next  = r_ran_valid_reg;
        r_ran_slot_next   = r_ran_slot_reg;
        r_ran_level_next  = r_ran_level_reg;
        r_done_valid_next = r_done_valid_reg;
        r_done_slot_next  = r_done_slot_reg;
        r_done_pid_next   = r_done_pid_reg;
        r_finish_next     = r_finish_reg;
        r_resp_next       = r_resp_reg;
        r_tat_next        = r_tat_reg;
        r_wait_next       = r_wait_reg;

        case (state_reg)
            ptrr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    r_tick_next       = tick_reg;
                    r_ran_valid_next  = 1'b0;
                    r_ran_slot_next   = '0;
                    r_ran_level_next  = 1'b0;
                    r_done_valid_next = 1'b0;
                    r_done_slot_next  = '0;
                    r_done_pid_next   = '0;
                    r_finish_next     = '0;
                    r_resp_next       = '0;
                    r_tat_next        = '0;
                    r_wait_next       = '0;
                    if (s_action == ptrr_pkg::ACT_LOAD) begin
                        cmd.load    = 1'b1;
                        cmd.slot    = s_slot;
                        cmd.pid     = s_pid;
                        cmd.arrival = s_arrival;
                        cmd.burst   = s_burst;
                        cmd.prio    = s_priority_req;
                        state_next  = ptrr_pkg::ST_OUT;
                    end else begin
                        scan_cnt_next = '0;
                        state_next    = ptrr_pkg::ST_SCAN;
                    end
                end
            end

            // Let the winner ripple through the whole row
            ptrr_pkg::ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == 5'(ptrr_pkg::SCAN_CYCLES - 1)) begin
                    best_next  = chain_best;
                    state_next = ptrr_pkg::ST_DECIDE;
                end
            end

            ptrr_pkg::ST_DECIDE: begin
                tick_next = tick_reg + 32'd1;
                if (!best_reg.valid && count_reg != '0) begin
                    rd_idx_next = prev_idx_reg;
                    state_next  = ptrr_pkg::ST_RR_DEMOTE;
                end else if (best_reg.valid && count_reg != '0 && !prev_valid_reg) begin
                    rd_idx_next = fifo_head_reg;
                    state_next  = ptrr_pkg::ST_PREEMPT;
                end else begin
                    rd_idx_next = best_reg.slot;
                    state_next  = ptrr_pkg::ST_START;
                end
            end

            // Level one idle: retire a finished previous runner
            ptrr_pkg::ST_RR_DEMOTE: begin
                if (prev_valid_reg && view.remaining == 16'd0) begin
                    cmd.set_dem = 1'b1;
                end
                prev_valid_next = 1'b0;
                rd_idx_next     = fifo_head_reg;
                state_next      = ptrr_pkg::ST_RR_HEAD;
            end

            ptrr_pkg::ST_RR_HEAD: begin
                push_slot_next = rd_idx_reg;
                state_next     = ptrr_pkg::ST_OUT;
                if (view.remaining == 16'd0) begin
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end else if (view.slice >= q) begin
                    cmd.slice_clr = 1'b1;
                    head_next     = head_reg + 1'b1;
                    count_next    = count_reg - 1'b1;
                    state_next    = ptrr_pkg::ST_RR_PUSH;
                end else begin
                    cmd.slice_inc    = 1'b1;
                    cmd.dec_rem      = 1'b1;
                    r_ran_valid_next = 1'b1;
                    r_ran_slot_next  = rd_idx_reg;
                    r_ran_level_next = 1'b1;
                    if (new_rem == 16'd0) begin
                        r_done_valid_next = 1'b1;
                        r_done_slot_next  = rd_idx_reg;
                        r_done_pid_next   = view.pid;
                        r_finish_next     = d_finish;
                        r_resp_next       = view.resp;
                        r_tat_next        = d_tat;
                        r_wait_next       = d_wait;
                        head_next         = head_reg + 1'b1;
                        count_next        = count_reg - 1'b1;
                    end else if (new_slice == {1'b0, q}) begin
                        cmd.slice_clr = 1'b1;
                        head_next     = head_reg + 1'b1;
                        count_next    = count_reg - 1'b1;
                        state_next    = ptrr_pkg::ST_RR_PUSH;
                    end
                end
            end

            ptrr_pkg::ST_RR_PUSH: begin
                if (count_reg < 5'(ptrr_pkg::NUM_SLOTS)) begin
                    fifo_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ptrr_pkg::ST_OUT;
            end

            // Level one resumes: rotate a partly served queue head
            ptrr_pkg::ST_PREEMPT: begin
                push_slot_next = rd_idx_reg;
                rd_idx_next    = best_reg.slot;
                state_next     = ptrr_pkg::ST_START;
                if (view.slice != '0 && view.slice <= q) begin
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = ptrr_pkg::ST_PREEMPT_PUSH;
                end
            end

            ptrr_pkg::ST_PREEMPT_PUSH: begin
                if (count_reg < 5'(ptrr_pkg::NUM_SLOTS)) begin
                    fifo_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ptrr_pkg::ST_START;
            end

            // Record response time on first service
            ptrr_pkg::ST_START: begin
                if (best_reg.valid && !view.started) begin
                    cmd.wr_resp = 1'b1;
                    cmd.resp    = r_tick_reg - {16'd0, view.arrival};
                end
                rd_idx_next = prev_idx_reg;
                state_next  = ptrr_pkg::ST_DEMOTE_PREV;
            end

            // Demote and queue a displaced previous runner
            ptrr_pkg::ST_DEMOTE_PREV: begin
                push_slot_next = prev_idx_reg;
                rd_idx_next    = best_reg.slot;
                state_next     = ptrr_pkg::ST_RUN_BEST;
                if (best_differs && prev_valid_reg && !view.demoted) begin
                    cmd.set_dem = 1'b1;
                    state_next  = ptrr_pkg::ST_PUSH_PREV;
                end
            end

            ptrr_pkg::ST_PUSH_PREV: begin
                if (count_reg < 5'(ptrr_pkg::NUM_SLOTS)) begin
                    fifo_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ptrr_pkg::ST_RUN_BEST;
            end

            ptrr_pkg::ST_RUN_BEST: begin
                push_slot_next  = best_reg.slot;
                prev_valid_next = best_reg.valid;
                prev_idx_next   = best_reg.slot;
                state_next      = ptrr_pkg::ST_OUT;
                if (best_reg.valid) begin
                    cmd.dec_rem      = 1'b1;
                    r_ran_valid_next = 1'b1;
                    r_ran_slot_next  = best_reg.slot;
                    r_ran_level_next = 1'b0;
                    if (new_rem == 16'd0) begin
                        cmd.set_dem       = 1'b1;
                        r_done_valid_next = 1'b1;
                        r_done_slot_next  = best_reg.slot;
                        r_done_pid_next   = view.pid;
                        r_finish_next     = d_finish;
                        r_resp_next       = view.resp;
                        r_tat_next        = d_tat;
                        r_wait_next       = d_wait;
                    end else if (served == {13'd0, q}) begin
                        cmd.set_dem = 1'b1;
                        state_next  = ptrr_pkg::ST_PUSH_BEST;
                    end
                end
            end

            ptrr_pkg::ST_PUSH_BEST: begin
                if (count_reg < 5'(ptrr_pkg::NUM_SLOTS)) begin
                    fifo_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ptrr_pkg::ST_OUT;
            end

            // Hold the item until the receiver takes it
            ptrr_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ptrr_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ptrr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tick_time     = r_tick_reg;
    assign m_ran_valid     = r_ran_valid_reg;
    assign m_ran_slot      = r_ran_slot_reg;
    assign m_ran_level     = r_ran_level_reg;
    assign m_done_valid    = r_done_valid_reg;
    assign m_done_slot     = r_done_slot_reg;
    assign m_done_pid      = r_done_pid_reg;
    assign m_finish_time   = r_finish_reg;
    assign m_response_time = r_resp_reg;
    assign m_turnaround    = r_tat_reg;
    assign m_waiting       = r_wait_reg;

endmodule
`default_nettype wire

/* test/priority_then_round_robin_scheduler_checker.sv */
module priority_then_round_robin_scheduler_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_action,
    input  wire logic [3:0]  s_slot,
    input  wire logic [15:0] s_pid,
    input  wire logic [15:0] s_arrival,
    input  wire logic [15:0] s_burst,
    input  wire logic [7:0]  s_priority_req,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_tick_time,
    input  wire logic        m_ran_valid,
    input  wire logic [3:0]  m_ran_slot,
    input  wire logic        m_ran_level,
    input  wire logic        m_done_valid,
    input  wire logic [3:0]  m_done_slot,
    input  wire logic [15:0] m_done_pid,
    input  wire logic [31:0] m_finish_time,
    input  wire logic [31:0] m_response_time,
    input  wire logic [31:0] m_turnaround,
    input  wire logic [31:0] m_waiting,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] tick_time;
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic        ran_level;
        logic        done_valid;
        logic [3:0]  done_slot;
        logic [15:0] done_pid;
        logic [31:0] finish_time;
        logic [31:0] response_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
    } sched_result_t;

    // Mirror of the scheduler state
    logic [31:0] tick_now;
    logic [15:0] arrival_of [ptrr_pkg::NUM_SLOTS];
    logic [15:0] burst_of   [ptrr_pkg::NUM_SLOTS];
    logic [15:0] pid_of     [ptrr_pkg::NUM_SLOTS];
    logic [15:0] left_of    [ptrr_pkg::NUM_SLOTS];
    logic [7:0]  prio_of    [ptrr_pkg::NUM_SLOTS];
    logic [31:0] resp_of    [ptrr_pkg::NUM_SLOTS];
    bit          demoted    [ptrr_pkg::NUM_SLOTS];
    bit          started    [ptrr_pkg::NUM_SLOTS];
    int          slice_of   [ptrr_pkg::NUM_SLOTS];
    int          rr_ring    [ptrr_pkg::NUM_SLOTS];
    int          rr_head;
    int          rr_cnt;
    int          last_runner;
    int          slots_in_use;
    int          quantum;

    sched_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic void rr_push(int s);
        if (rr_cnt < ptrr_pkg::NUM_SLOTS) begin
            rr_ring[(rr_head + rr_cnt) % ptrr_pkg::NUM_SLOTS] = s;
            rr_cnt++;
        end
    endfunction

    function automatic void rr_pop();
        if (rr_cnt > 0) begin
            rr_head = (rr_head + 1) % ptrr_pkg::NUM_SLOTS;
            rr_cnt--;
        end
    endfunction

    function automatic void mark_done(inout sched_result_t r, input int s,
                                      input logic [31:0] fin);
        logic [31:0] tat;
        tat = fin - 32'(arrival_of[s]);
        r.done_valid    = 1'b1;
        r.done_slot     = 4'(s);
        r.done_pid      = pid_of[s];
        r.finish_time   = fin;
        r.response_time = resp_of[s];
        r.turnaround    = tat;
        r.waiting       = tat - 32'(burst_of[s]);
    endfunction

    // Serve the round-robin head for one tick
    function automatic void rr_serve(inout sched_result_t r, input logic [31:0] now,
                                     input int q);
        int f;
        if (rr_cnt == 0) return;
        f = rr_ring[rr_head];
        if (left_of[f] == 0) begin
            rr_pop();
            return;
        end
        if (slice_of[f] >= q) begin
            slice_of[f] = 0;
            rr_pop();
            rr_push(f);
            return;
        end
        slice_of[f]++;
        left_of[f]--;
        r.ran_valid = 1'b1;
        r.ran_slot  = 4'(f);
        r.ran_level = 1'b1;
        if (left_of[f] == 0) begin
            mark_done(r, f, now + 32'd1);
            rr_pop();
        end else if (slice_of[f] == q) begin
            slice_of[f] = 0;
            rr_pop();
            rr_push(f);
        end
    endfunction

    function automatic sched_result_t schedule_item(logic act, logic [3:0] sl,
            logic [15:0] pid, logic [15:0] arr, logic [15:0] bur, logic [7:0] pri);
        sched_result_t r;
        logic [31:0]   now;
        int            q, n, best, best_prio, f, s;
        r = '0;
        now = tick_now;
        r.tick_time = now;
        q = (quantum == 0) ? 1 : quantum;
        n = (slots_in_use > ptrr_pkg::NUM_SLOTS) ? ptrr_pkg::NUM_SLOTS : slots_in_use;
        best = -1;
        best_prio = 1000;
        if (act == ptrr_pkg::ACT_LOAD) begin
            s = sl;
            pid_of[s] = pid;
            arrival_of[s] = arr;
            burst_of[s] = bur;
            prio_of[s] = pri;
            left_of[s] = bur;
            demoted[s] = 0;
            started[s] = 0;
            slice_of[s] = 0;
            return r;
        end
        tick_now = now + 32'd1;
        for (int i = 0; i < n; i++) begin
            if (32'(arrival_of[i]) <= now && int'(prio_of[i]) < best_prio &&
                left_of[i] > 0 && !demoted[i]) begin
                best_prio = prio_of[i];
                best = i;
            end
        end
        // Level one idle: fall through to the round-robin queue
        if (best < 0 && rr_cnt > 0) begin
            if (last_runner >= 0 && left_of[last_runner] == 0) demoted[last_runner] = 1;
            last_runner = -1;
            rr_serve(r, now, q);
            return r;
        end
        // Level one resumes: rotate a partly served head
        if (best >= 0 && rr_cnt > 0 && last_runner < 0) begin
            f = rr_ring[rr_head];
            if (slice_of[f] > 0 && slice_of[f] <= q) begin
                rr_pop();
                rr_push(f);
            end
        end
        if (best >= 0 && !started[best]) begin
            resp_of[best] = now - 32'(arrival_of[best]);
            started[best] = 1;
        end
        if (best != last_runner && last_runner >= 0 && !demoted[last_runner]) begin
            rr_push(last_runner);
            demoted[last_runner] = 1;
        end
        if (best >= 0) begin
            left_of[best]--;
            r.ran_valid = 1'b1;
            r.ran_slot  = 4'(best);
            r.ran_level = 1'b0;
            if (left_of[best] == 0) begin
                demoted[best] = 1;
                mark_done(r, best, now + 32'd1);
            end else if (32'(burst_of[best]) - 32'(left_of[best]) == 32'(q)) begin
                demoted[best] = 1;
                rr_push(best);
            end
        end
        last_runner = best;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Track config, predict on accepted input, compare on accepted output
    always @(posedge aclk) begin
        sched_result_t e;
        if (!aresetn) begin
            tick_now = 0;
            for (int i = 0; i < ptrr_pkg::NUM_SLOTS; i++) begin
                demoted[i] = 0;
                started[i] = 0;
                slice_of[i] = 0;
                rr_ring[i] = 0;
            end
            rr_head = 0;
            rr_cnt = 0;
            last_runner = -1;
            slots_in_use = 0;
            quantum = ptrr_pkg::DEFAULT_QUANTUM;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == ptrr_pkg::CFG_PROCESS_COUNT) slots_in_use = cfg_data;
                else quantum = cfg_data[3:0];
            end
            if (s_valid && s_ready)
                expected_results.push_back(schedule_item(s_action, s_slot, s_pid,
                    s_arrival, s_burst, s_priority_req));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item, tick_time %0h", $time, m_tick_time);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    compare_field("tick_time", e.tick_time, m_tick_time);
                    compare_field("ran_valid", e.ran_valid, m_ran_valid);
                    compare_field("ran_slot", e.ran_slot, m_ran_slot);
                    compare_field("ran_level", e.ran_level, m_ran_level);
                    compare_field("done_valid", e.done_valid, m_done_valid);
                    compare_field("done_slot", e.done_slot, m_done_slot);
                    compare_field("done_pid", e.done_pid, m_done_pid);
                    compare_field("finish_time", e.finish_time, m_finish_time);
                    compare_field("response_time", e.response_time, m_response_time);
                    compare_field("turnaround", e.turnaround, m_turnaround);
                    compare_field("waiting", e.waiting, m_waiting);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* test/priority_then_round_robin_scheduler_top_tb.sv */
module priority_then_round_robin_scheduler_top_tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_action = ptrr_pkg::ACT_LOAD;
    logic [3:0]  s_slot = 0;
    logic [15:0] s_pid = 0;
    logic [15:0] s_arrival = 0;
    logic [15:0] s_burst = 0;
    logic [7:0]  s_priority_req = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_tick_time;
    logic        m_ran_valid;
    logic [3:0]  m_ran_slot;
    logic        m_ran_level;
    logic        m_done_valid;
    logic [3:0]  m_done_slot;
    logic [15:0] m_done_pid;
    logic [31:0] m_finish_time;
    logic [31:0] m_response_time;
    logic [31:0] m_turnaround;
    logic [31:0] m_waiting;
    logic        cfg_wr_en = 0;
    logic        cfg_index = ptrr_pkg::CFG_PROCESS_COUNT;
    logic [4:0]  cfg_data = 0;

    int fail_count;
    int pending;
    int ticks_sent = 0;
    bit calm = 0;
    int stall_left = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    priority_then_round_robin_scheduler_top dut (.*);

    priority_then_round_robin_scheduler_checker checker_i (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random back-pressure on the result side
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_item(logic act, logic [3:0] sl, logic [15:0] pid,
                             logic [15:0] arr, logic [15:0] bur, logic [7:0] pri);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_slot <= sl;
        s_pid <= pid;
        s_arrival <= arr;
        s_burst <= bur;
        s_priority_req <= pri;
        do @(posedge aclk); while (!s_ready);
        if (act == ptrr_pkg::ACT_TICK) ticks_sent++;
    endtask

    task automatic send_tick();
        send_item(ptrr_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
    endtask

    // Hold the input, then wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_load();
        int r;
        logic [15:0] arr, bur;
        logic [7:0]  pri;
        r = $urandom_range(0, 99);
        arr = (r < 85) ? 16'(ticks_sent + $urandom_range(0, 6)) : 16'($urandom);
        r = $urandom_range(0, 99);
        bur = (r < 82) ? 16'($urandom_range(1, 8)) : (r < 92) ? 16'd0 : 16'($urandom);
        pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        send_item(ptrr_pkg::ACT_LOAD, 4'($urandom), 16'($urandom), arr, bur, pri);
    endtask

    int phase_count[8] = '{16, 31, 0, 16, 17, 8, 16, 3};
    int phase_quant[8] = '{4, 15, 0, 1, 2, 3, 7, 5};

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fill every slot before any tick scans them
        write_reg(ptrr_pkg::CFG_PROCESS_COUNT, 5'd16);
        write_reg(ptrr_pkg::CFG_TIME_QUANTUM, 5'd2);
        send_item(ptrr_pkg::ACT_LOAD, 4'd0, 16'hFFFF, 16'd0, 16'd3, 8'd0);
        send_item(ptrr_pkg::ACT_LOAD, 4'd1, 16'h0000, 16'd0, 16'd2, 8'd0);
        send_item(ptrr_pkg::ACT_LOAD, 4'd2, 16'h1234, 16'd0, 16'd0, 8'd0);
        send_item(ptrr_pkg::ACT_LOAD, 4'd3, 16'h5A5A, 16'd1, 16'd5, 8'hFF);
        send_item(ptrr_pkg::ACT_LOAD, 4'd4, 16'hA5A5, 16'd2, 16'd1, 8'd1);
        send_item(ptrr_pkg::ACT_LOAD, 4'd5, 16'h0F0F, 16'hFFFF, 16'hFFFF, 8'd7);
        for (int i = 6; i < 16; i++)
            send_item(ptrr_pkg::ACT_LOAD, 4'(i), 16'($urandom), 16'($urandom_range(0, 9)),
                      16'($urandom_range(1, 4)), 8'($urandom_range(2, 9)));
        repeat (8) send_tick();
        drain();

        // Random phases over several register settings
        for (int p = 0; p < 8; p++) begin
            write_reg(ptrr_pkg::CFG_PROCESS_COUNT, 5'(phase_count[p]));
            write_reg(ptrr_pkg::CFG_TIME_QUANTUM, 5'(phase_quant[p]));
            calm = (p == 2);
            for (int k = 0; k < 110; k++) begin
                if ($urandom_range(0, 99) < 72) send_tick();
                else send_random_load();
            end
            drain();
        end

        if (fail_count == 0)
            $display("priority_then_round_robin_scheduler_top_tb passed");
        else
            $display("priority_then_round_robin_scheduler_top_tb failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("priority_then_round_robin_scheduler_top_tb failed");
        $finish;
    end

endmodule
